// ----- sv/ecq_pkg.sv -----
// ----------------------------------------------------------------------------
// ecq_pkg
// shared types, constants and floor helpers of the elevator call queue
// controller
// ----------------------------------------------------------------------------
package ecq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 1'b1;

    // opcode of an input item
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CALL = 1'b1;

    localparam logic [8:0]       HOME_POS  = 9'd330;
    localparam logic [2:0]       HOME_FLR  = 3'd1;
    localparam logic [CFG_W-1:0] DWELL_RST = 10'd250;
    localparam logic [CFG_W-1:0] GAP_RST   = 10'd205;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_MOVING   = 3'd1,
        PH_DWELL    = 3'd2,
        PH_GAP_NEXT = 3'd3,
        PH_GAP_PARK = 3'd4,
        PH_PARKING  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [2:0] pickup;
        logic [2:0] dest;
    } t_call;

    typedef struct packed {
        logic  is_call;
        t_call call;
    } t_cmd;

    typedef struct packed {
        logic [8:0] car_position;
        t_phase     phase;
        logic [2:0] target_floor;
        logic [3:0] queue_count;
        logic       call_dropped;
    } t_result;

    // car position of a floor, floor 1 at the bottom of the shaft
    function automatic logic [8:0] floor_pos(input logic [2:0] f);
        logic [8:0] p;
        unique case (f)
            3'd0:    p = 9'd430;
            3'd1:    p = 9'd330;
            3'd2:    p = 9'd230;
            3'd3:    p = 9'd130;
            3'd4:    p = 9'd30;
            default: p = HOME_POS;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] clamp_floor(input logic [2:0] f);
        logic [2:0] c;
        priority if (f == 3'd0) begin
            c = 3'd1;
        end else if (f > 3'd4) begin
            c = 3'd4;
        end else begin
            c = f;
        end
        return c;
    endfunction

endpackage

// ----- sv/ecq_ram.sv -----
// ----------------------------------------------------------------------------
// ecq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ecq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ecq_fifo.sv -----
// ----------------------------------------------------------------------------
// ecq_fifo
// two-entry register queue used between the stages of the controller
// ----------------------------------------------------------------------------
module ecq_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_rd_ptr;
    logic             r_wr_ptr;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/ecq_front.sv -----
// ----------------------------------------------------------------------------
// ecq_front
// takes items, decodes the opcode and clamps floors, queues commands
// ----------------------------------------------------------------------------
module ecq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_opcode,
    input  logic [2:0]    i_pickup_floor,
    input  logic [2:0]    i_dest_floor,
    output logic          o_cmd_valid,
    output ecq_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    import ecq_pkg::*;

    t_cmd w_cmd_in;
    logic w_empty;

    // out-of-range floors fold onto the nearest real floor
    always_comb begin
        w_cmd_in.is_call     = (i_opcode == OP_CALL);
        w_cmd_in.call.pickup = clamp_floor(i_pickup_floor);
        w_cmd_in.call.dest   = clamp_floor(i_dest_floor);
    end

    ecq_fifo #(
        .WIDTH($bits(t_cmd))
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .o_full (o_full),
        .i_data (w_cmd_in),
        .o_empty(w_empty),
        .i_pop  (i_cmd_pop),
        .o_data (o_cmd)
    );

    assign o_cmd_valid = !w_empty;

endmodule

// ----- sv/ecq_back.sv -----
// ----------------------------------------------------------------------------
// ecq_back
// car engine: call queue, position, phase sequencer and wait timer
// ----------------------------------------------------------------------------
module ecq_back #(
    parameter int QUEUE_DEPTH = ecq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ecq_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [ecq_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_cmd_valid,
    input  ecq_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    input  logic                          i_res_full,
    output logic                          o_res_push,
    output ecq_pkg::t_result              o_res
);

    import ecq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    logic [CFG_W-1:0] r_dwell;
    logic [CFG_W-1:0] r_gap;
    logic [8:0]       r_pos,      n_pos;
    t_phase           r_phase,    n_phase;
    logic [2:0]       r_heading,  n_heading;
    logic [CFG_W-1:0] r_wait,     n_wait;
    logic [CW-1:0]    r_count,    n_count;
    logic [PW-1:0]    r_head_ptr, n_head_ptr;
    logic [PW-1:0]    r_tail_ptr, n_tail_ptr;
    t_call            r_head,     n_head;
    logic             r_head_pend, n_head_pend;

    logic             w_fire;
    logic             w_ram_we;
    logic [5:0]       w_ram_rdata;
    t_call            w_head;
    logic [8:0]       w_goal;
    logic [8:0]       w_step_pos;
    logic             w_at_goal;
    logic             w_at_dest;
    logic [CFG_W:0]   w_wait_nxt;
    logic             w_dwell_done;
    logic             w_gap_done;
    logic [CW-1:0]    w_cnt_dec;
    logic             w_push_ok;
    logic             w_call_start;
    logic [2:0]       w_svc_heading;
    logic [2:0]       w_new_heading;
    logic             w_dropped;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    assign w_fire     = i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = w_fire;
    assign o_res_push = w_fire;

    // the head entry comes from the ram once a call has left the queue,
    // from the bypass register after a call into an empty queue
    assign w_head = r_head_pend ? t_call'(w_ram_rdata) : r_head;

    assign w_goal     = (r_phase == PH_PARKING) ? HOME_POS : floor_pos(r_heading);
    assign w_step_pos = (r_pos > w_goal) ? r_pos - 9'd1 :
                        (r_pos < w_goal) ? r_pos + 9'd1 : r_pos;
    assign w_at_goal  = (w_step_pos == w_goal);
    assign w_at_dest  = (w_step_pos == floor_pos(w_head.dest));

    assign w_wait_nxt   = {1'b0, r_wait} + (CFG_W + 1)'(1);
    assign w_dwell_done = (w_wait_nxt >= {1'b0, r_dwell});
    assign w_gap_done   = (w_wait_nxt >= {1'b0, r_gap});

    assign w_cnt_dec    = (r_count != '0) ? r_count - CW'(1) : r_count;
    assign w_push_ok    = (r_count < CNT_MAX);
    assign w_call_start = w_push_ok && (r_count == '0);

    assign w_svc_heading = (r_pos == floor_pos(w_head.pickup)) ? w_head.dest
                                                               : w_head.pickup;
    assign w_new_heading = (r_pos == floor_pos(i_cmd.call.pickup)) ? i_cmd.call.dest
                                                                   : i_cmd.call.pickup;

    // phase sequencer, next state
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            if (i_cmd.is_call) begin
                if (w_call_start) begin
                    n_phase = PH_MOVING;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_MOVING: begin
                        if (w_at_goal) begin
                            if (w_at_dest) begin
                                n_phase = (w_cnt_dec != '0) ? PH_GAP_NEXT : PH_GAP_PARK;
                            end else begin
                                n_phase = PH_DWELL;
                            end
                        end
                    end
                    PH_DWELL: begin
                        if (w_dwell_done) begin
                            n_phase = PH_MOVING;
                        end
                    end
                    PH_GAP_NEXT: begin
                        if (w_gap_done) begin
                            n_phase = PH_MOVING;
                        end
                    end
                    PH_GAP_PARK: begin
                        if (w_gap_done) begin
                            n_phase = PH_PARKING;
                        end
                    end
                    PH_PARKING: begin
                        if (w_at_goal) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // datapath updates
    always_comb begin
        n_pos       = r_pos;
        n_heading   = r_heading;
        n_wait      = r_wait;
        n_count     = r_count;
        n_head_ptr  = r_head_ptr;
        n_tail_ptr  = r_tail_ptr;
        n_head      = r_head;
        n_head_pend = r_head_pend;
        w_ram_we    = 1'b0;
        w_dropped   = 1'b0;
        if (w_fire) begin
            if (i_cmd.is_call) begin
                if (!w_push_ok) begin
                    w_dropped = 1'b1;
                end else begin
                    w_ram_we   = 1'b1;
                    n_tail_ptr = ptr_inc(r_tail_ptr);
                    n_count    = r_count + CW'(1);
                    if (w_call_start) begin
                        n_head      = i_cmd.call;
                        n_head_pend = 1'b0;
                        n_heading   = w_new_heading;
                        n_wait      = '0;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_pos = r_pos;
                    end
                    PH_MOVING: begin
                        n_pos = w_step_pos;
                        if (w_at_goal) begin
                            n_wait = '0;
                            if (w_at_dest) begin
                                n_count   = w_cnt_dec;
                                n_heading = 3'd0;
                                if (r_count != '0) begin
                                    n_head_ptr  = ptr_inc(r_head_ptr);
                                    n_head_pend = 1'b1;
                                end
                            end
                        end
                    end
                    PH_DWELL: begin
                        if (w_dwell_done) begin
                            n_wait    = '0;
                            n_heading = w_head.dest;
                        end else begin
                            n_wait = w_wait_nxt[CFG_W-1:0];
                        end
                    end
                    PH_GAP_NEXT: begin
                        if (w_gap_done) begin
                            n_wait    = '0;
                            n_heading = w_svc_heading;
                        end else begin
                            n_wait = w_wait_nxt[CFG_W-1:0];
                        end
                    end
                    PH_GAP_PARK: begin
                        if (w_gap_done) begin
                            n_wait    = '0;
                            n_heading = HOME_FLR;
                        end else begin
                            n_wait = w_wait_nxt[CFG_W-1:0];
                        end
                    end
                    PH_PARKING: begin
                        n_pos = w_step_pos;
                        if (w_at_goal) begin
                            n_heading = 3'd0;
                        end
                    end
                    default: begin
                        n_pos = r_pos;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res.car_position = n_pos;
        o_res.phase        = n_phase;
        o_res.target_floor = n_heading;
        o_res.queue_count  = 4'(n_count);
        o_res.call_dropped = w_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell     <= DWELL_RST;
            r_gap       <= GAP_RST;
            r_pos       <= HOME_POS;
            r_phase     <= PH_IDLE;
            r_heading   <= 3'd0;
            r_wait      <= '0;
            r_count     <= '0;
            r_head_ptr  <= '0;
            r_tail_ptr  <= '0;
            r_head_pend <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_DWELL: r_dwell <= i_cfg_wdata;
                    CFG_GAP:   r_gap   <= i_cfg_wdata;
                endcase
            end
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_heading   <= n_heading;
            r_wait      <= n_wait;
            r_count     <= n_count;
            r_head_ptr  <= n_head_ptr;
            r_tail_ptr  <= n_tail_ptr;
            r_head_pend <= n_head_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end

    // read address follows the next head, so the registered read data holds the entry of the current head pointer
    ecq_ram #(
        .WIDTH($bits(t_call)),
        .DEPTH(QUEUE_DEPTH)
    ) u_call_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_tail_ptr),
        .i_wdata(i_cmd.call),
        .i_raddr(n_head_ptr),
        .o_rdata(w_ram_rdata)
    );

endmodule

// ----- sv/elevator_call_queue_controller.sv -----
// ----------------------------------------------------------------------------
// elevator_call_queue_controller
// four-floor car controller with a call queue, one result item per item
// ----------------------------------------------------------------------------
// input channel: push / full, with opcode, pickup_floor and dest_floor. an
//   opcode of tick advances the car by one time step, a call opcode queues a
//   call (pickup, destination); a call that meets a full queue is refused
// result channel: empty / pop. every input item yields exactly one result
//   item: car position, phase, target floor, queue count and the dropped flag
// configuration: i_cfg_wr_en, i_cfg_addr, i_cfg_wdata; index 0 is the dwell
//   time at the pickup floor, index 1 the gap after a trip, both in ticks
// throughput: one item per cycle while the result buffer has room; the back
//   end updates position, phase, timer and call ram head/tail in one step
// an accepted item passes the command queue, then the back end, into the
//   result buffer, from which the receiver pops its result.
// the front end holds up to two decoded items and the result buffer two
//   results; when pop is held low the result buffer fills, the back end stops
//   and then full rises once the command queue is full as well
// reset: car parked at floor 1 and idle, queues empty, dwell 250 and gap 205
//   ticks; the call ram needs no clearing pass, items are taken right away
// ----------------------------------------------------------------------------
module elevator_call_queue_controller #(
    parameter int QUEUE_DEPTH = ecq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_wr_en,
    input  logic [ecq_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [ecq_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input items
    input  logic                          push,
    output logic                          full,
    input  logic                          i_opcode,
    input  logic [2:0]                    i_pickup_floor,
    input  logic [2:0]                    i_dest_floor,
    // result items
    output logic                          empty,
    input  logic                          pop,
    output logic [8:0]                    o_car_position,
    output logic [2:0]                    o_phase,
    output logic [2:0]                    o_target_floor,
    output logic [3:0]                    o_queue_count,
    output logic                          o_call_dropped
);

    import ecq_pkg::*;

    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_cmd_pop;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res;
    t_result w_res_out;

    // front end: decode and clamp, two-entry command queue
    ecq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_opcode      (i_opcode),
        .i_pickup_floor(i_pickup_floor),
        .i_dest_floor  (i_dest_floor),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    // back end: call queue and car state, one command a cycle while the result buffer has room
    ecq_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    // result buffer decouples the receiver from the car update
    ecq_fifo #(
        .WIDTH($bits(t_result))
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .o_full (w_res_full),
        .i_data (w_res),
        .o_empty(empty),
        .i_pop  (pop),
        .o_data (w_res_out)
    );

    assign o_car_position = w_res_out.car_position;
    assign o_phase        = w_res_out.phase;
    assign o_target_floor = w_res_out.target_floor;
    assign o_queue_count  = w_res_out.queue_count;
    assign o_call_dropped = w_res_out.call_dropped;

    // a tick never reports a refused call
    a_tick_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && !w_cmd.is_call) |-> !w_res.call_dropped)
        else $error("tick item flagged as dropped call");

    // a refused call only happens with the queue at its depth
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.call_dropped) |-> (w_res.queue_count == 4'(QUEUE_DEPTH)))
        else $error("call dropped while queue had room");

    // an idle car stands at floor 1 with no target
    a_idle_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.phase == PH_IDLE) |->
        (w_res.car_position == HOME_POS && w_res.target_floor == 3'd0))
        else $error("idle car away from home or with a target");

    // the car only moves on a call that is still held
    a_moving_has_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.phase == PH_MOVING) |-> (w_res.queue_count != 4'd0))
        else $error("car moving with an empty call queue");

endmodule

// ----- tb/elevator_call_queue_controller_tb.sv -----
// ----------------------------------------------------------------------------
// elevator_call_queue_controller_tb
// self-checking bench for the four-floor car controller with its call queue
// ----------------------------------------------------------------------------
// a clocked driver pushes ticks and calls taken from a backlog that the
// stimulus process fills, and a clocked monitor pops result items and checks
// them field by field against a cycle-free model of the car kept in the bench.
// a short directed run at the reset timings comes first. random runs follow
// at several dwell and gap settings, extremes included. the runs differ in
// how often each side idles, and one run holds off the receiver until the
// input side is pushed back.
// ----------------------------------------------------------------------------
module elevator_call_queue_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecq_pkg::*;

    localparam int QUEUE_DEPTH    = QUEUE_DEPTH_DEF;
    localparam int HOLD_OFF_LEN   = 300;    // long receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item moving
    localparam int DRAIN_CYCLES   = 8;      // settle time after the last result
    localparam int RUN_ITEMS      = 146;    // random items per run

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr     = '0;
    logic [CFG_W-1:0]     i_cfg_wdata    = '0;
    logic                 push           = 1'b0;
    logic                 full;
    logic                 i_opcode       = OP_TICK;
    logic [2:0]           i_pickup_floor = 3'd0;
    logic [2:0]           i_dest_floor   = 3'd0;
    logic                 empty;
    logic                 pop            = 1'b0;
    logic [8:0]           o_car_position;
    logic [2:0]           o_phase;
    logic [2:0]           o_target_floor;
    logic [3:0]           o_queue_count;
    logic                 o_call_dropped;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_cmd    call_backlog[$];   // items waiting to be pushed, head is on offer
    t_result car_status_q[$];   // predicted result items, oldest first

    int tx_idle_pct;            // chance in a hundred that the driver idles
    int rx_stall_pct;           // chance in a hundred that the monitor stalls
    bit pressure_on;            // receiver holds off once for a long stretch
    int hold_count;
    int idle_cycles;
    int mismatch_cnt;

    // car model: own copy of the queue, the car and the timings
    t_call      pend_calls[$];  // calls held, head is the one being served
    logic [8:0] car_pos;
    t_phase     car_ph;
    logic [2:0] car_goal;
    logic [9:0] car_timer;
    logic [9:0] dwell_len;
    logic [9:0] gap_len;

    elevator_call_queue_controller #(
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_pickup_floor (i_pickup_floor),
        .i_dest_floor   (i_dest_floor),
        .empty          (empty),
        .pop            (pop),
        .o_car_position (o_car_position),
        .o_phase        (o_phase),
        .o_target_floor (o_target_floor),
        .o_queue_count  (o_queue_count),
        .o_call_dropped (o_call_dropped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // car model
    // ------------------------------------------------------------------------

    // shaft position of floor 1..4, floor 1 at the bottom
    function automatic logic [8:0] shaft_pos(input logic [2:0] flr);
        int p;
        p = 430 - 100 * int'(flr);
        return p[8:0];
    endfunction

    // out-of-range floors fold onto the nearest real floor
    function automatic logic [2:0] clip_floor(input logic [2:0] flr);
        if (flr == 3'd0) return 3'd1;
        if (flr > 3'd4) return 3'd4;
        return flr;
    endfunction

    function automatic void nudge_car(input logic [8:0] goal);
        if (car_pos > goal) begin
            car_pos = car_pos - 9'd1;
        end else if (car_pos < goal) begin
            car_pos = car_pos + 9'd1;
        end
    endfunction

    // one tick of a wait; a length of zero behaves as one
    function automatic bit timer_expired(input logic [9:0] len);
        int n;
        n = int'(car_timer) + 1;
        if (n >= int'(len)) begin
            car_timer = '0;
            return 1'b1;
        end
        car_timer = n[9:0];
        return 1'b0;
    endfunction

    // head call starts; standing at the pickup floor skips the dwell
    function automatic void begin_trip();
        if (car_pos == shaft_pos(pend_calls[0].pickup)) begin
            car_goal = pend_calls[0].dest;
        end else begin
            car_goal = pend_calls[0].pickup;
        end
        car_ph    = PH_MOVING;
        car_timer = '0;
    endfunction

    function automatic t_result predict_status(input t_cmd cmd);
        t_result r;
        t_call   c;
        int      n;
        r.call_dropped = 1'b0;
        if (cmd.is_call == OP_CALL) begin
            if (pend_calls.size() >= QUEUE_DEPTH) begin
                r.call_dropped = 1'b1;
            end else begin
                c.pickup = clip_floor(cmd.call.pickup);
                c.dest   = clip_floor(cmd.call.dest);
                pend_calls.push_back(c);
                // first call in an empty queue also cuts short a gap or parking
                if (pend_calls.size() == 1) begin_trip();
            end
        end else begin
            case (car_ph)
                PH_MOVING: begin
                    nudge_car(shaft_pos(car_goal));
                    if (car_pos == shaft_pos(car_goal)) begin
                        if (car_pos == shaft_pos(pend_calls[0].dest)) begin
                            // arrival at the destination: call leaves the queue
                            void'(pend_calls.pop_front());
                            car_goal  = '0;
                            car_timer = '0;
                            car_ph    = (pend_calls.size() > 0) ? PH_GAP_NEXT : PH_GAP_PARK;
                        end else begin
                            car_ph    = PH_DWELL;
                            car_timer = '0;
                        end
                    end
                end
                PH_DWELL: begin
                    if (timer_expired(dwell_len)) begin
                        car_goal = pend_calls[0].dest;
                        car_ph   = PH_MOVING;
                    end
                end
                PH_GAP_NEXT: begin
                    if (timer_expired(gap_len)) begin_trip();
                end
                PH_GAP_PARK: begin
                    if (timer_expired(gap_len)) begin
                        car_goal = HOME_FLR;
                        car_ph   = PH_PARKING;
                    end
                end
                PH_PARKING: begin
                    nudge_car(HOME_POS);
                    if (car_pos == HOME_POS) begin
                        car_goal = '0;
                        car_ph   = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
        n              = pend_calls.size();
        r.car_position = car_pos;
        r.phase        = car_ph;
        r.target_floor = car_goal;
        r.queue_count  = n[3:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // calls lean towards the lower floors so that trips stay short
    function automatic logic [2:0] pick_floor();
        logic [31:0] r;
        r = $urandom;
        if (r[7:0] < 8'd140) return {2'b00, r[8]};
        if (r[7:0] < 8'd205) return 3'd2;
        return r[10:8];
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd        c;
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(99) < 15) begin
            c.is_call     = OP_CALL;
            c.call.pickup = pick_floor();
            c.call.dest   = pick_floor();
        end else begin
            // floor fields are don't-care on a tick, toggle them anyway
            c.is_call     = OP_TICK;
            c.call.pickup = r[2:0];
            c.call.dest   = r[5:3];
        end
        return c;
    endfunction

    function automatic void add_item(input logic op, input logic [2:0] p, input logic [2:0] d);
        t_cmd c;
        c.is_call     = op;
        c.call.pickup = p;
        c.call.dest   = d;
        call_backlog.push_back(c);
    endfunction

    task automatic wait_drained();
        while (call_backlog.size() != 0 || car_status_q.size() != 0) @(negedge i_clk);
    endtask

    // register write; the model takes the value while nothing is in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_DWELL) begin
            dwell_len = val;
        end else begin
            gap_len = val;
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] dwell, input logic [CFG_W-1:0] gap,
                             input int tx_pct, input int rx_pct, input bit hold_off);
        wait_drained();
        write_reg(CFG_DWELL, dwell);
        write_reg(CFG_GAP, gap);
        @(negedge i_clk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        pressure_on  = hold_off;
        repeat (RUN_ITEMS) call_backlog.push_back(random_cmd());
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t mismatch in %s: expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the head of the backlog, keeps it up while full is high
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : item_driver
        bit offer_held;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            offer_held = 1'b0;
            if (push && !full) begin
                // item taken at this edge: predict its result now
                car_status_q.push_back(predict_status(call_backlog[0]));
                void'(call_backlog.pop_front());
            end else if (push) begin
                offer_held = 1'b1;
            end
            if (!offer_held) begin
                if (call_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    push           <= 1'b1;
                    i_opcode       <= call_backlog[0].is_call;
                    i_pickup_floor <= call_backlog[0].call.pickup;
                    i_dest_floor   <= call_backlog[0].call.dest;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks every popped result item against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (car_status_q.size() == 0) begin
                    $display("%0t unexpected result item: expected none, actual position %0d",
                             $time, o_car_position);
                    mismatch_cnt++;
                end else begin
                    want = car_status_q.pop_front();
                    check_field("car_position", want.car_position, o_car_position);
                    check_field("phase", want.phase, o_phase);
                    check_field("target_floor", want.target_floor, o_target_floor);
                    check_field("queue_count", want.queue_count, o_queue_count);
                    check_field("call_dropped", want.call_dropped, o_call_dropped);
                end
            end
            // long hold-off first, so the block backs up to its input
            if (pressure_on && hold_count < HOLD_OFF_LEN) begin
                hold_count++;
                pop <= 1'b0;
            end else begin
                if (!pressure_on) hold_count = 0;
                pop <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no item moving on either side for too long ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no item moved for %0d cycles", $time, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        car_pos      = HOME_POS;
        car_ph       = PH_IDLE;
        car_goal     = '0;
        car_timer    = '0;
        dwell_len    = DWELL_RST;
        gap_len      = GAP_RST;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        pressure_on  = 1'b0;
        hold_count   = 0;
        idle_cycles  = 0;
        mismatch_cnt = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed run at the reset timings
        @(negedge i_clk);
        add_item(OP_TICK, 3'd0, 3'd0);  // tick while idle
        add_item(OP_CALL, 3'd1, 3'd1);  // car already at pickup, same floor
        add_item(OP_TICK, 3'd7, 3'd7);  // arrives at once, gap before parking
        add_item(OP_TICK, 3'd0, 3'd0);
        add_item(OP_CALL, 3'd0, 3'd0);  // floor zero folds to one, cuts the gap
        add_item(OP_TICK, 3'd5, 3'd2);
        add_item(OP_CALL, 3'd2, 3'd1);  // cuts the gap again, pickup elsewhere
        add_item(OP_TICK, 3'd0, 3'd0);
        add_item(OP_CALL, 3'd1, 3'd1);  // fill the queue behind the trip
        add_item(OP_CALL, 3'd0, 3'd1);
        add_item(OP_CALL, 3'd1, 3'd0);
        add_item(OP_CALL, 3'd1, 3'd1);
        add_item(OP_CALL, 3'd0, 3'd0);
        add_item(OP_CALL, 3'd1, 3'd1);
        add_item(OP_CALL, 3'd2, 3'd2);  // queue now full
        add_item(OP_CALL, 3'd7, 3'd7);  // refused, all ones
        add_item(OP_CALL, 3'd4, 3'd6);  // refused
        add_item(OP_TICK, 3'd0, 3'd0);
        add_item(OP_TICK, 3'd0, 3'd0);
        add_item(OP_TICK, 3'd0, 3'd0);

        // shortest timings, no idling
        run_phase(10'd1, 10'd1, 0, 0, 1'b0);
        // zero dwell and a short gap, sender mostly idle
        run_phase(10'd0, 10'd3, 75, 0, 1'b0);
        // zero gap, receiver mostly stalled
        run_phase(CFG_W'($urandom_range(6, 2)), 10'd0, 0, 75, 1'b0);
        // longest timings, both sides idling now and then
        run_phase(10'd1023, 10'd1023, 10, 10, 1'b0);
        // receiver holds off while the sender keeps offering
        run_phase(10'd2, 10'd2, 0, 0, 1'b1);

        wait_drained();
        pressure_on = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && car_status_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ecq_pkg.sv
sv/ecq_ram.sv
sv/ecq_fifo.sv
sv/ecq_front.sv
sv/ecq_back.sv
sv/elevator_call_queue_controller.sv
tb/elevator_call_queue_controller_tb.sv
